/* rtl/mrb_pkg.sv */
// mrb_pkg: shared types, codes and constants for the modbus register bank
// used by mrb_ctrl, mrb_dpath and modbus_register_bank_unit; no dependencies
package mrb_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam logic [15:0] ANALOG_BASE = 16'd20000;
    localparam logic [15:0] DIGITAL_ON  = 16'h00FF;
    localparam logic [15:0] DIGITAL_OFF = 16'h0000;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] reg_address;
        logic [15:0] write_value;
    } in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        hit;
        logic        table_full;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FETCH,
        ST_COMPARE,
        ST_POST
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the input item
        logic add_write;   // append an entry at the fill count
        logic scan_start;  // scan index to zero
        logic scan_read;   // read tag and data at the scan index
        logic scan_next;   // advance the scan index
        logic data_write;  // update data at the scan index
        logic pend_load;   // hold the result flags below
        logic pend_hit;
        logic pend_full;
        logic post;        // move the held result to the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       match;
        logic       last;
        logic       out_free;
    } status_t;

endpackage

/* rtl/mrb_ctrl.sv */
// mrb_ctrl: sequencer for add, read and write items of the register bank
// depends on mrb_pkg; drives mrb_dpath through cmd_t and reads status_t
module mrb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrb_pkg::status_t  status,
    output mrb_pkg::cmd_t     cmd
);

    mrb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mrb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mrb_pkg::ST_DISPATCH;
                end
            end
            mrb_pkg::ST_DISPATCH: begin
                if ((status.op == mrb_pkg::OP_READ || status.op == mrb_pkg::OP_WRITE)
                        && !status.empty) begin
                    state_next = mrb_pkg::ST_FETCH;
                end else begin
                    state_next = mrb_pkg::ST_POST;
                end
            end
            mrb_pkg::ST_FETCH: begin
                state_next = mrb_pkg::ST_COMPARE;
            end
            mrb_pkg::ST_COMPARE: begin
                if (status.match || status.last) begin
                    state_next = mrb_pkg::ST_POST;
                end else begin
                    state_next = mrb_pkg::ST_FETCH;
                end
            end
            mrb_pkg::ST_POST: begin
                if (status.out_free) begin
                    state_next = mrb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            mrb_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            mrb_pkg::ST_DISPATCH: begin
                priority if (status.op == mrb_pkg::OP_ADD) begin
                    cmd.pend_load = 1'b1;
                    cmd.pend_full = status.full;
                    cmd.add_write = !status.full;
                end else if (status.op == mrb_pkg::OP_READ
                        || status.op == mrb_pkg::OP_WRITE) begin
                    // nothing stored yet means a miss without scanning
                    cmd.scan_start = 1'b1;
                    cmd.pend_load  = status.empty;
                end else begin
                    cmd.pend_load = 1'b1;
                end
            end
            mrb_pkg::ST_FETCH: begin
                cmd.scan_read = 1'b1;
            end
            mrb_pkg::ST_COMPARE: begin
                if (status.match) begin
                    cmd.pend_load  = 1'b1;
                    cmd.pend_hit   = 1'b1;
                    cmd.data_write = (status.op == mrb_pkg::OP_WRITE);
                end else if (status.last) begin
                    cmd.pend_load = 1'b1;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            mrb_pkg::ST_POST: begin
                cmd.post = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/mrb_dpath.sv */
// mrb_dpath: tag and data memories, fill count, scan index and result registers
// depends on mrb_pkg; steered by mrb_ctrl through cmd_t
module mrb_dpath #(
    parameter int ENTRIES = mrb_pkg::ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrb_pkg::in_t      s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output mrb_pkg::out_t     m_payload,
    input  mrb_pkg::cmd_t     cmd,
    output mrb_pkg::status_t  status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [15:0] tag_mem  [0:ENTRIES-1];
    logic [15:0] data_mem [0:ENTRIES-1];

    mrb_pkg::in_t   item_reg;
    logic [CNT_W-1:0] used_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]    tag_q_reg;
    logic [15:0]    data_q_reg;
    logic [15:0]    pend_data_reg;
    logic           pend_hit_reg;
    logic           pend_full_reg;
    mrb_pkg::out_t  out_reg;
    logic           out_valid_reg;

    logic [15:0]    store_value;
    logic [15:0]    pend_data_next;

    // digital registers keep only on or off
    always_comb begin
        if (item_reg.reg_address < mrb_pkg::ANALOG_BASE) begin
            store_value = (item_reg.write_value != 16'd0) ? mrb_pkg::DIGITAL_ON
                                                          : mrb_pkg::DIGITAL_OFF;
        end else begin
            store_value = item_reg.write_value;
        end
    end

    assign pend_data_next = (cmd.pend_hit && item_reg.operation == mrb_pkg::OP_READ)
                            ? data_q_reg : 16'd0;

    always_ff @(posedge aclk) begin
        if (cmd.add_write) begin
            tag_mem[used_reg[IDX_W-1:0]] <= item_reg.reg_address;
        end
        if (cmd.scan_read) begin
            tag_q_reg <= tag_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_write) begin
            data_mem[used_reg[IDX_W-1:0]] <= 16'd0;
        end else if (cmd.data_write) begin
            data_mem[idx_reg] <= store_value;
        end
        if (cmd.scan_read) begin
            data_q_reg <= data_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_payload;
        end
        if (cmd.scan_start) begin
            idx_reg <= '0;
        end else if (cmd.scan_next) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.pend_load) begin
            pend_data_reg <= pend_data_next;
            pend_hit_reg  <= cmd.pend_hit;
            pend_full_reg <= cmd.pend_full;
        end
        if (cmd.post) begin
            out_reg.read_data  <= pend_data_reg;
            out_reg.hit        <= pend_hit_reg;
            out_reg.table_full <= pend_full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.add_write) begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (cmd.post) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign status.op       = item_reg.operation;
    assign status.full     = (used_reg == CNT_W'(ENTRIES));
    assign status.empty    = (used_reg == '0);
    assign status.match    = (tag_q_reg == item_reg.reg_address);
    assign status.last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_reg);
    assign status.out_free = !out_valid_reg || m_ready;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond table depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_read |-> (CNT_W'(idx_reg) < used_reg))
        else $error("scan reads an entry that was never added");

    a_no_add_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_write |-> !status.full)
        else $error("add into a full table");

    a_post_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |=> m_valid)
        else $error("posted result not presented");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload.hit && m_payload.table_full))
        else $error("hit and table_full together");

endmodule

/* rtl/modbus_register_bank_unit.sv */
// modbus_register_bank_unit: top level of the sparse modbus register table
// depends on mrb_pkg, mrb_ctrl and mrb_dpath
//
// Sparse Modbus register table of up to ENTRIES address-tagged 16-bit
// entries, kept in one tag memory and one data memory with a fill count.
// One item is handled at a time. Adds, refused adds and unused codes go
// straight from dispatch to the output stage. Reads and writes scan the
// entries in the order they were added through the single memory read
// port, one entry at a time, stopping at the first matching entry; on a
// miss every stored entry is examined, and an empty table is not scanned.
// The next item is accepted once the result has been loaded into the
// output register, even while that result still waits.
// Memory contents are not cleared at reset; only the fill count and the
// output valid flag are.
module modbus_register_bank_unit #(
    parameter int ENTRIES = mrb_pkg::ENTRIES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mrb_pkg::in_t   s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output mrb_pkg::out_t  m_payload
);

    mrb_pkg::cmd_t    cmd;
    mrb_pkg::status_t status;

    mrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mrb_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for modbus_register_bank_unit, directed table then random
// depends on mrb_pkg and modbus_register_bank_unit; checked against an in-bench register table
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_ENTRIES  = mrb_pkg::ENTRIES_DEF;
    localparam int PHASE_ITEMS  = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 20;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        mrb_pkg::in_t  item;
        bit            typed;
        mrb_pkg::out_t answer;
    } dir_row_t;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    mrb_pkg::in_t  s_payload = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    mrb_pkg::out_t m_payload;

    // in-bench copy of the register table
    logic [15:0] bank_tag [NUM_ENTRIES];
    logic [15:0] bank_data [NUM_ENTRIES];
    int          bank_used = 0;

    mrb_pkg::out_t expected_answers [$];
    dir_row_t      directed_rows [$];
    int       error_count  = 0;
    int       result_count = 0;
    int       cycle_count  = 0;
    int       idle_pct     = 0;
    int       stall_pct    = 0;
    int       hold_req     = 0;
    int       hold_ack     = 0;
    int       hold_left    = 0;

    modbus_register_bank_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modbus_register_bank_unit test failed");
            $finish;
        end
    end

    // earliest matching entry answers; returns NUM_ENTRIES on a miss
    function automatic int find_slot(input logic [15:0] addr);
        for (int i = 0; i < bank_used; i++) begin
            if (bank_tag[i] == addr)
                return i;
        end
        return NUM_ENTRIES;
    endfunction

    function automatic mrb_pkg::out_t table_access(input mrb_pkg::in_t item);
        mrb_pkg::out_t res;
        int            slot;
        res = '0;
        case (item.operation)
            mrb_pkg::OP_ADD: begin
                if (bank_used >= NUM_ENTRIES) begin
                    res.table_full = 1'b1;
                end else begin
                    bank_tag[bank_used]  = item.reg_address;
                    bank_data[bank_used] = 16'h0000;
                    bank_used++;
                end
            end
            mrb_pkg::OP_READ: begin
                slot = find_slot(item.reg_address);
                if (slot < NUM_ENTRIES) begin
                    res.hit       = 1'b1;
                    res.read_data = bank_data[slot];
                end
            end
            mrb_pkg::OP_WRITE: begin
                slot = find_slot(item.reg_address);
                if (slot < NUM_ENTRIES) begin
                    res.hit = 1'b1;
                    if (item.reg_address < mrb_pkg::ANALOG_BASE)
                        bank_data[slot] = (item.write_value != 16'h0000)
                                          ? mrb_pkg::DIGITAL_ON : mrb_pkg::DIGITAL_OFF;
                    else
                        bank_data[slot] = item.write_value;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void directed_row(input logic [1:0] op, input logic [15:0] addr,
                                         input logic [15:0] val, input bit typed,
                                         input logic [15:0] rd, input bit h, input bit f);
        dir_row_t row;
        row.item.operation    = op;
        row.item.reg_address  = addr;
        row.item.write_value  = val;
        row.typed             = typed;
        row.answer.read_data  = rd;
        row.answer.hit        = h;
        row.answer.table_full = f;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [15:0] fresh_address();
        case ($urandom_range(0, 3))
            0: begin
                // small pool so that duplicates and boundary addresses come up often
                case ($urandom_range(0, 7))
                    0: return 16'd0;
                    1: return 16'd1;
                    2: return 16'd19999;
                    3: return 16'd20000;
                    4: return 16'd20001;
                    5: return 16'hFFFF;
                    6: return 16'd150;
                    default: return 16'd30000;
                endcase
            end
            1: return 16'($urandom_range(0, 19999));
            2: return 16'($urandom_range(20000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch on result %0d: %s got %0h want %0h", result_count, what, got, want);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input mrb_pkg::in_t item, input bit typed,
                             input mrb_pkg::out_t answer);
        mrb_pkg::out_t want;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        want = table_access(item);
        if (typed)
            want = answer;
        expected_answers.push_back(want);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(negedge aclk);
        @(negedge aclk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        mrb_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected transfer", int'(m_payload), 0);
            end else begin
                want = expected_answers.pop_front();
                if (m_payload.read_data !== want.read_data)
                    report_mismatch("read_data", int'(m_payload.read_data),
                                    int'(want.read_data));
                if (m_payload.hit !== want.hit)
                    report_mismatch("hit", int'(m_payload.hit), int'(want.hit));
                if (m_payload.table_full !== want.table_full)
                    report_mismatch("table_full", int'(m_payload.table_full),
                                    int'(want.table_full));
            end
            result_count++;
        end
    end

    initial begin : stimulus
        mrb_pkg::in_t item;
        int           counted;
        int           pick;
        int           add_weight;

        // misses and ignored codes on the empty table, then adds and first hits
        directed_row(mrb_pkg::OP_READ,  16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_WRITE, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(OP_UNUSED,         16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_ADD,   16'd0,     16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_ADD,   16'd19999, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_ADD,   16'd20000, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_ADD,   16'hFFFF,  16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'd0,     16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_WRITE, 16'd0,     16'h0001, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'd0,     16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
        // digital boundary: any nonzero value folds to the on code
        directed_row(mrb_pkg::OP_WRITE, 16'd19999, 16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'd19999, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_WRITE, 16'd19999, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'd19999, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
        // analog side keeps the whole word
        directed_row(mrb_pkg::OP_WRITE, 16'd20000, 16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'd20000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_WRITE, 16'hFFFF,  16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'hFFFF,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_WRITE, 16'hFFFF,  16'hA5A5, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'hFFFF,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
        // duplicate add: the older entry keeps answering
        directed_row(mrb_pkg::OP_ADD,   16'd20000, 16'h5A5A, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_WRITE, 16'd20000, 16'h1234, 1'b1, 16'h0000, 1'b1, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'd20000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
        directed_row(OP_UNUSED,         16'd20000, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);
        directed_row(mrb_pkg::OP_READ,  16'd12345, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].answer);
        wait_drained();

        // phases: no idling, sender idle, receiver stalling, both, none again
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin idle_pct = 65; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 65; end
                3: begin idle_pct = 9;  stall_pct <= 9;  end
                default: begin idle_pct = 0; stall_pct <= 0; end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (phase == 0 && counted == 20)
                    hold_req <= hold_req + 1;
                add_weight = (bank_used >= NUM_ENTRIES) ? 8 : 30;
                pick = $urandom_range(0, 99);
                item.write_value = random_value();
                if (pick < 5) begin
                    item.operation   = OP_UNUSED;
                    item.reg_address = 16'($urandom);
                end else begin
                    if (pick < 5 + add_weight)
                        item.operation = mrb_pkg::OP_ADD;
                    else if ($urandom_range(0, 1) == 0)
                        item.operation = mrb_pkg::OP_READ;
                    else
                        item.operation = mrb_pkg::OP_WRITE;
                    if (item.operation != mrb_pkg::OP_ADD && bank_used > 0 &&
                        $urandom_range(0, 99) < 70)
                        item.reg_address = bank_tag[$urandom_range(0, bank_used - 1)];
                    else
                        item.reg_address = fresh_address();
                    counted++;
                end
                send_item(item, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("modbus_register_bank_unit test passed");
        else
            $display("modbus_register_bank_unit test failed");
        $finish;
    end

endmodule
